// ----- rtl/core/srv_pkg.sv -----
// ----------------------------------------------------------------------------
// srv_pkg
// Shared types, constants and the bytewise CRC-16/XMODEM step for the stored
// record verifier.
// ----------------------------------------------------------------------------
`default_nettype none

package srv_pkg;

	localparam int unsigned SLOT_BYTES  = 5120;
	localparam int unsigned MIN_PAYLOAD = 10;
	localparam int unsigned MAX_PAYLOAD = SLOT_BYTES - 8;

	localparam int unsigned MAGIC_W = 16;
	localparam int unsigned CAP_W   = 13;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned POS_W   = 13;
	localparam int unsigned CRC_W   = 16;
	localparam int unsigned CFG_W   = 16;

	localparam logic [CRC_W-1:0]   CRC_POLY        = 16'h1021;
	localparam logic [MAGIC_W-1:0] MAGIC_RESET     = 16'h494E;
	localparam logic [CAP_W-1:0]   CAPACITY_RESET  = CAP_W'(MAX_PAYLOAD);

	// register indexes of the configuration port
	typedef enum logic [0:0] {
		REG_MAGIC           = 1'b0,
		REG_BUFFER_CAPACITY = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_CRC_HI  = 3'd3,
		PH_CRC_LO  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_MAGIC  = 3'd1,
		ST_SIZE   = 3'd2,
		ST_BUFFER = 3'd3,
		ST_CRC    = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	// one result as handed from the parser to the output register
	typedef struct packed {
		logic          valid;
		kind_t         kind;
		logic [7:0]    payload_byte;
		status_t       status;
		logic [12:0]   payload_size;
		logic          end_of_record;
	} result_t;

	// CRC-16/XMODEM over one byte, MSB first
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
			input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/srv_in_stage.sv -----
// ----------------------------------------------------------------------------
// srv_in_stage
// Input register: holds one accepted request until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_in_stage
	import srv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       in_start,
	input  wire logic [7:0] in_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic            start_s1,
	output logic [7:0]      byte_s1
);

	logic take;

	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			start_s1 <= in_start;
			byte_s1  <= in_byte;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/srv_parser.sv -----
// ----------------------------------------------------------------------------
// srv_parser
// Record parser: header checks, payload forwarding and CRC compare, one byte
// per step.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_parser
	import srv_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic               start_s1,
	input  wire logic [7:0]         byte_s1,
	input  wire logic [MAGIC_W-1:0] magic_want,
	input  wire logic [CAP_W-1:0]   buffer_capacity,
	output result_t                 result
);

	phase_t             phase_q, phase_d, phase_e;
	logic [POS_W-1:0]   pos_q, pos_d, pos_e, pos_inc;
	logic [MAGIC_W-1:0] magic_q, magic_d, magic_e, magic_nx;
	logic [LEN_W-1:0]   len_q, len_d, len_e, len_nx;
	logic [CRC_W-1:0]   hcrc_q, hcrc_d, hcrc_e;
	logic [CRC_W-1:0]   pcrc_q, pcrc_d, pcrc_e;
	logic [7:0]         crc_hi_q, crc_hi_d, crc_hi_e;
	logic [CRC_W-1:0]   crc_in, crc_out, crc_field;
	logic               magic_bad, size_bad, buffer_bad, header_done, payload_done;

	// a start byte restarts the parser with cleared state
	always_comb begin
		phase_e  = start_s1 ? PH_HEADER : phase_q;
		pos_e    = start_s1 ? '0 : pos_q;
		magic_e  = start_s1 ? '0 : magic_q;
		len_e    = start_s1 ? '0 : len_q;
		hcrc_e   = start_s1 ? '0 : hcrc_q;
		pcrc_e   = start_s1 ? '0 : pcrc_q;
		crc_hi_e = start_s1 ? '0 : crc_hi_q;
	end

	// one CRC unit serves header and payload
	assign crc_in     = (phase_e == PH_HEADER) ? hcrc_e : pcrc_e;
	assign crc_out    = crc_byte(crc_in, byte_s1);
	assign pos_inc    = pos_e + POS_W'(1);
	assign magic_nx   = (pos_e < POS_W'(2)) ? {magic_e[7:0], byte_s1} : magic_e;
	assign len_nx     = (pos_e < POS_W'(2)) ? len_e : {len_e[LEN_W-9:0], byte_s1};
	assign magic_bad  = (pos_inc == POS_W'(2)) && (magic_nx != magic_want);
	assign header_done = (pos_inc == POS_W'(6));
	assign size_bad   = (len_nx < LEN_W'(MIN_PAYLOAD)) || (len_nx > LEN_W'(MAX_PAYLOAD));
	assign buffer_bad = (len_nx > {{(LEN_W-CAP_W){1'b0}}, buffer_capacity});
	assign payload_done = ({{(LEN_W-POS_W){1'b0}}, pos_inc} >= len_e);
	assign crc_field  = {crc_hi_e, byte_s1};

	// next state
	always_comb begin
		phase_d  = phase_e;
		pos_d    = pos_e;
		magic_d  = magic_e;
		len_d    = len_e;
		hcrc_d   = hcrc_e;
		pcrc_d   = pcrc_e;
		crc_hi_d = crc_hi_e;
		unique case (phase_e)
			PH_HEADER: begin
				hcrc_d  = crc_out;
				magic_d = magic_nx;
				len_d   = len_nx;
				pos_d   = pos_inc;
				if (magic_bad) begin
					phase_d = PH_IDLE;
				end else if (header_done) begin
					if (size_bad || buffer_bad) begin
						phase_d = PH_IDLE;
					end else begin
						pos_d   = '0;
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				pcrc_d = crc_out;
				pos_d  = pos_inc;
				if (payload_done) begin
					phase_d = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				crc_hi_d = byte_s1;
				phase_d  = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// result of this step
	always_comb begin
		result               = '0;
		result.kind          = KIND_PAYLOAD;
		result.status        = ST_OK;
		unique case (phase_e)
			PH_HEADER: begin
				if (magic_bad) begin
					result.valid  = step;
					result.kind   = KIND_STATUS;
					result.status = ST_MAGIC;
				end else if (header_done && size_bad) begin
					result.valid  = step;
					result.kind   = KIND_STATUS;
					result.status = ST_SIZE;
				end else if (header_done && buffer_bad) begin
					result.valid  = step;
					result.kind   = KIND_STATUS;
					result.status = ST_BUFFER;
				end
				result.end_of_record = (result.kind == KIND_STATUS);
			end
			PH_PAYLOAD: begin
				result.valid        = step;
				result.payload_byte = byte_s1;
			end
			PH_CRC_LO: begin
				result.valid         = step;
				result.kind          = KIND_STATUS;
				result.end_of_record = 1'b1;
				if (crc_field != (hcrc_e ^ pcrc_e)) begin
					result.status = ST_CRC;
				end else begin
					result.payload_size = len_e[12:0];
				end
			end
			default: begin
				result.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			magic_q  <= '0;
			len_q    <= '0;
			hcrc_q   <= '0;
			pcrc_q   <= '0;
			crc_hi_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			magic_q  <= magic_d;
			len_q    <= len_d;
			hcrc_q   <= hcrc_d;
			pcrc_q   <= pcrc_d;
			crc_hi_q <= crc_hi_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/srv_out_stage.sv -----
// ----------------------------------------------------------------------------
// srv_out_stage
// Output register: holds a result request until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_out_stage
	import srv_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire result_t result,
	output logic         advance,
	output logic         out_valid,
	input  wire logic    out_ready,
	output logic [23:0]  out_data,
	output logic         out_user,
	output logic         out_last
);

	logic        valid_q;
	kind_t       kind_q;
	logic [7:0]  byte_q;
	status_t     status_q;
	logic [12:0] size_q;
	logic        last_q;

	assign advance   = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = {size_q, status_q, byte_q};
	assign out_user  = kind_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			kind_q   <= result.kind;
			byte_q   <= result.payload_byte;
			status_q <= result.status;
			size_q   <= result.payload_size;
			last_q   <= result.end_of_record;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/stored_record_verifier.sv -----
// Stored record verifier: one record byte per request, one byte per cycle
// sustained; input stalls only while a result waits at the output. An
// accepted byte waits in the input register and is parsed there; its
// result, if any, is registered in the output register. The single-byte
// CRC step between the two registers sets the cycle time. Reset clears the
// parser to idle and loads the register defaults (magic 0x494E, capacity 5112).
// ----------------------------------------------------------------------------
// stored_record_verifier
// Checks magic, length and CRC-16/XMODEM of a stored record and forwards
// its payload bytes, ending each record not cut short with one status result.
// ----------------------------------------------------------------------------
`default_nettype none

module stored_record_verifier
	import srv_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] byte_value
	input  wire logic               s_tuser,   // [0] record_start
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [23:0]             m_tdata,   // [7:0] payload_byte, [10:8] status_code,
	                                           // [23:11] payload_size
	output logic                    m_tuser,   // [0] result_kind
	output logic                    m_tlast,   // end_of_record
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	logic               advance, valid_s1, start_s1, step;
	logic [7:0]         byte_s1;
	logic [MAGIC_W-1:0] magic_cfg_q;
	logic [CAP_W-1:0]   capacity_cfg_q;
	result_t            result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_cfg_q    <= MAGIC_RESET;
			capacity_cfg_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAGIC:           magic_cfg_q    <= cfg_data[MAGIC_W-1:0];
				REG_BUFFER_CAPACITY: capacity_cfg_q <= cfg_data[CAP_W-1:0];
				default:             magic_cfg_q    <= magic_cfg_q;
			endcase
		end
	end

	assign step = valid_s1 && advance;

	srv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_start (s_tuser),
		.in_byte  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.start_s1 (start_s1),
		.byte_s1  (byte_s1)
	);

	srv_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.start_s1        (start_s1),
		.byte_s1         (byte_s1),
		.magic_want      (magic_cfg_q),
		.buffer_capacity (capacity_cfg_q),
		.result          (result)
	);

	srv_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire

// ----- test/stored_record_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stored_record_checker
// Watches the byte and result streams and the register port of the stored
// record verifier, tracks the parser on its own and compares every result.
// ----------------------------------------------------------------------------

module stored_record_checker
	import srv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic             s_tuser,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [23:0]      m_tdata,
	input  logic             m_tuser,
	input  logic             m_tlast,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               errors,
	output int               pending
);

	typedef struct {
		kind_t       kind;
		logic [7:0]  data;
		status_t     code;
		logic [12:0] pay_size;
		logic        last;
	} record_out_t;

	record_out_t outputs_due[$];

	logic [15:0] magic_cfg;
	logic [12:0] capacity_cfg;

	phase_t      stage;
	logic [12:0] count;
	logic [15:0] magic_word;
	logic [31:0] length_word;
	logic [15:0] head_crc;
	logic [15:0] body_crc;
	logic [7:0]  crc_high;

	// bitwise form: feed each data bit into the top of the register
	function automatic logic [15:0] xmodem_update(input logic [15:0] crc,
			input logic [7:0] data);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ data[i];
			c  = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic finish_record(input status_t code, input logic [12:0] pay_size);
		record_out_t r;
		r.kind     = KIND_STATUS;
		r.data     = 8'h00;
		r.code     = code;
		r.pay_size = pay_size;
		r.last     = 1'b1;
		outputs_due.push_back(r);
		stage = PH_IDLE;
	endtask

	task automatic track_byte(input logic first, input logic [7:0] data);
		record_out_t r;
		if (first) begin
			stage       = PH_HEADER;
			count       = '0;
			magic_word  = '0;
			length_word = '0;
			head_crc    = '0;
			body_crc    = '0;
			crc_high    = '0;
		end
		case (stage)
			PH_HEADER: begin
				head_crc = xmodem_update(head_crc, data);
				if (count < 2) begin
					magic_word = {magic_word[7:0], data};
				end else begin
					length_word = {length_word[23:0], data};
				end
				count++;
				if (count == 2 && magic_word != magic_cfg) begin
					finish_record(ST_MAGIC, '0);
				end else if (count == 6) begin
					// size range first, then the buffer limit
					if (length_word < MIN_PAYLOAD || length_word > MAX_PAYLOAD) begin
						finish_record(ST_SIZE, '0);
					end else if (length_word > capacity_cfg) begin
						finish_record(ST_BUFFER, '0);
					end else begin
						count = '0;
						stage = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				body_crc = xmodem_update(body_crc, data);
				count++;
				if (count >= length_word) begin
					stage = PH_CRC_HI;
				end
				r.kind     = KIND_PAYLOAD;
				r.data     = data;
				r.code     = ST_OK;
				r.pay_size = '0;
				r.last     = 1'b0;
				outputs_due.push_back(r);
			end
			PH_CRC_HI: begin
				crc_high = data;
				stage    = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				if ({crc_high, data} != (head_crc ^ body_crc)) begin
					finish_record(ST_CRC, '0);
				end else begin
					finish_record(ST_OK, length_word[12:0]);
				end
			end
			default: begin
				stage = PH_IDLE;
			end
		endcase
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		record_out_t due;
		if (!arst_n) begin
			magic_cfg    = MAGIC_RESET;
			capacity_cfg = CAPACITY_RESET;
			stage        = PH_IDLE;
			count        = '0;
			magic_word   = '0;
			length_word  = '0;
			head_crc     = '0;
			body_crc     = '0;
			crc_high     = '0;
			outputs_due.delete();
			errors       = 0;
			pending      = 0;
		end else begin
			// compare first so a result never meets a request of the same edge
			if (m_tvalid && m_tready) begin
				if (outputs_due.size() == 0) begin
					$display("%0t: unexpected result: expected none, got tdata %h tuser %b tlast %b",
						$time, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					due = outputs_due.pop_front();
					check_field("result_kind", due.kind, m_tuser);
					check_field("payload_byte", due.data, m_tdata[7:0]);
					check_field("status_code", due.code, m_tdata[10:8]);
					check_field("payload_size", due.pay_size, m_tdata[23:11]);
					check_field("end_of_record", due.last, m_tlast);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_MAGIC) begin
					magic_cfg = cfg_data[15:0];
				end else if (cfg_index == REG_BUFFER_CAPACITY) begin
					capacity_cfg = cfg_data[12:0];
				end
			end
			if (s_tvalid && s_tready) begin
				track_byte(s_tuser, s_tdata);
			end
			pending = outputs_due.size();
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams stored records through the verifier under several magic and
// capacity settings: well-formed records with random payloads, bad magic,
// bad and oversized lengths, corrupted CRCs and records cut short by a
// restart, with bursty requests and a stalling result consumer.
// ----------------------------------------------------------------------------

module tb;
	import srv_pkg::*;

	localparam int LIMIT = 500000;

	typedef enum int {
		FORM_GOOD,
		FORM_BAD_CRC,
		FORM_BAD_MAGIC,
		FORM_BAD_SIZE,
		FORM_TOO_BIG,
		FORM_CUT
	} rec_form_t;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_ONE_IN_THREE,
		READY_MOSTLY
	} ready_mode_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata   = 8'h00;
	logic             s_tuser   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [23:0]      m_tdata;
	logic             m_tuser;
	logic             m_tlast;
	logic             cfg_we    = 1'b0;
	logic [0:0]       cfg_index = REG_MAGIC;
	logic [CFG_W-1:0] cfg_data  = '0;

	int          errors;
	int          pending;
	int          cycles       = 0;
	int          items_sent   = 0;
	int          burst_left   = 0;
	bit          steady       = 1'b0;
	bit          last_cut     = 1'b0;
	bit          squeeze_req  = 1'b0;
	bit          squeeze_done = 1'b0;
	logic [15:0] cur_magic    = MAGIC_RESET;
	logic [12:0] cur_cap      = CAPACITY_RESET;

	stored_record_verifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	stored_record_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("** stored_record_verifier: FAILED **");
			$finish;
		end
	end

	task automatic offer_byte(input logic first, input logic [7:0] value);
		if (burst_left == 0) begin
			if (!steady) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	function automatic int pick_length();
		int hi;
		hi = (cur_cap < MIN_PAYLOAD) ? MIN_PAYLOAD : int'(cur_cap);
		// keep most payloads short
		if ($urandom_range(0, 9) < 8) begin
			hi = (hi > 40) ? 40 : hi;
		end else begin
			hi = (hi > 120) ? 120 : hi;
		end
		return $urandom_range(MIN_PAYLOAD, hi);
	endfunction

	function automatic rec_form_t pick_form();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return FORM_GOOD;
		if (r < 62) return FORM_BAD_CRC;
		if (r < 72) return FORM_BAD_MAGIC;
		if (r < 80) return FORM_BAD_SIZE;
		if (r < 88) return FORM_TOO_BIG;
		return FORM_CUT;
	endfunction

	task automatic stream_record(input rec_form_t form, input int fixed_len);
		logic [7:0]  bytes_q[$];
		logic [47:0] hdr;
		logic [31:0] len;
		logic [15:0] magic;
		logic [15:0] head;
		logic [15:0] body;
		logic [15:0] crc;
		logic [7:0]  b;
		bit          full;
		int          n;
		int          hi;
		int          cut;
		magic = cur_magic;
		if (form == FORM_BAD_MAGIC) begin
			magic = cur_magic ^ 16'($urandom_range(1, 65535));
		end
		case (form)
			FORM_BAD_SIZE: begin
				case ($urandom_range(0, 3))
					0: len = $urandom_range(0, MIN_PAYLOAD - 1);
					1: len = $urandom_range(MAX_PAYLOAD + 1, 6000);
					2: len = $urandom | 32'h0001_0000;
					default: len = 32'hFFFF_FFFF;
				endcase
			end
			FORM_TOO_BIG: begin
				if (cur_cap < MAX_PAYLOAD) begin
					hi = int'(cur_cap) + 40;
					hi = (hi > MAX_PAYLOAD) ? MAX_PAYLOAD : hi;
					len = $urandom_range(int'(cur_cap) + 1, hi);
				end else begin
					len = MAX_PAYLOAD + 1;
				end
			end
			default: begin
				len = (fixed_len != 0) ? fixed_len : pick_length();
			end
		endcase
		full = (form == FORM_GOOD || form == FORM_BAD_CRC || form == FORM_CUT);
		hdr  = {magic, len};
		head = '0;
		for (int i = 0; i < 6; i++) begin
			b    = hdr[47 - 8*i -: 8];
			head = crc_byte(head, b);
			bytes_q.push_back(b);
		end
		// early errors carry a little trailing junk that must be ignored
		n    = full ? int'(len) : $urandom_range(0, 8);
		body = '0;
		for (int i = 0; i < n; i++) begin
			b    = 8'($urandom);
			body = crc_byte(body, b);
			bytes_q.push_back(b);
		end
		if (full) begin
			crc = head ^ body;
			if (form == FORM_BAD_CRC) begin
				crc = crc ^ 16'($urandom_range(1, 65535));
			end
			bytes_q.push_back(crc[15:8]);
			bytes_q.push_back(crc[7:0]);
		end
		if (form == FORM_CUT) begin
			cut     = $urandom_range(1, bytes_q.size() - 1);
			bytes_q = bytes_q[0:cut-1];
		end
		last_cut = (form == FORM_CUT);
		foreach (bytes_q[i]) begin
			offer_byte(i == 0, bytes_q[i]);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		// a trailing ignored byte may still be in the pipe
		repeat (4) @(posedge clk);
	endtask

	task automatic program_slot(input logic [15:0] magic, input logic [12:0] cap);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAGIC;
		cfg_data  <= magic;
		@(posedge clk);
		cfg_index <= REG_BUFFER_CAPACITY;
		cfg_data  <= {3'b000, cap};
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_magic = magic;
		cur_cap   = cap;
	endtask

	// result consumer: picks a new stall pattern each time its span runs out
	initial begin : receiver
		ready_mode_t mode;
		int          span;
		int          tick;
		mode = READY_ALWAYS;
		span = 0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeeze_done) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				squeeze_done = 1'b1;
			end
			if (span == 0) begin
				mode = ready_mode_t'($urandom_range(0, 3));
				span = $urandom_range(16, 128);
			end
			span--;
			tick++;
			case (mode)
				READY_ALWAYS:       m_tready <= 1'b1;
				READY_COIN:         m_tready <= 1'($urandom_range(0, 1));
				READY_ONE_IN_THREE: m_tready <= (tick % 3 == 0);
				default:            m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	initial begin : stimulus
		logic [15:0] magic;
		logic [12:0] cap;
		int          phase_start;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte while idle, all-zero magic, all-ones length, minimum record
		offer_byte(1'b0, 8'hFF);
		offer_byte(1'b1, 8'h00);
		offer_byte(1'b0, 8'h00);
		offer_byte(1'b1, MAGIC_RESET[15:8]);
		offer_byte(1'b0, MAGIC_RESET[7:0]);
		repeat (4) offer_byte(1'b0, 8'hFF);
		stream_record(FORM_GOOD, MIN_PAYLOAD);
		drain_results();

		for (int p = 0; p < 7; p++) begin
			steady = 1'b0;
			case (p)
				0: begin magic = 16'h0000; cap = '0; end
				1: begin magic = 16'hFFFF; cap = CAPACITY_RESET; end
				2: begin magic = 16'h444C; cap = 13'(MIN_PAYLOAD); end
				3: begin magic = 16'h4341; cap = 13'($urandom_range(11, 200)); end
				4: begin
					magic       = MAGIC_RESET;
					cap         = CAPACITY_RESET;
					steady      = 1'b1;
					squeeze_req = 1'b1;
				end
				5: begin
					magic  = 16'($urandom);
					cap    = 13'($urandom_range(MIN_PAYLOAD, MAX_PAYLOAD));
					steady = 1'b1;
				end
				default: begin magic = MAGIC_RESET; cap = 13'($urandom_range(20, 60)); end
			endcase
			program_slot(magic, cap);
			phase_start = items_sent;
			// never leave a record open across a register write
			while (items_sent - phase_start < 40 || last_cut) begin
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 3)) offer_byte(1'b0, 8'($urandom));
				end
				stream_record(pick_form(), 0);
			end
			drain_results();
		end

		repeat (8) @(posedge clk);

		if (errors == 0 && pending == 0) begin
			$display("** stored_record_verifier: PASSED **");
		end else begin
			$display("** stored_record_verifier: FAILED **");
		end
		$finish;
	end

endmodule
